// ----- src/dsu_pkg.sv -----
package dsu_pkg;

  localparam int NodeW   = 10;
  localparam int RankW   = 4;
  localparam logic [RankW-1:0] RankMax = 4'd15;

  typedef enum logic [0:0] {
    OpFind  = 1'b0,
    OpMerge = 1'b1
  } dsu_op_e;

  typedef enum logic [2:0] {
    SClear,
    SIdle,
    SReduce,
    SWalk,
    SComp,
    SRankA,
    SRankB,
    SOut
  } dsu_state_e;

  typedef struct packed {
    dsu_op_e          opcode;
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
  } dsu_req_t;

  typedef struct packed {
    logic [NodeW-1:0] root;
    logic             already_joined;
  } dsu_rsp_t;

  // number of conditional-subtract steps that fold a node field below nodes
  function automatic int red_steps(int nodes);
    int s;
    s = 0;
    for (int k = 0; k < NodeW; k++) begin
      if ((nodes << k) < (1 << NodeW)) begin
        s++;
      end
    end
    return s;
  endfunction

endpackage

// ----- src/dsu_ram.sv -----
module dsu_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/disjoint_set_union_engine_unit.sv -----
// Union-find engine with path compression and union by rank.
// Input channel in_valid_i/in_ready_o carries one request item: opcode
// (find or merge), node_a and node_b. Output channel out_valid_o/out_ready_i
// carries exactly one result item per request: the root and, for a merge,
// whether both nodes already shared a set. Items are served one at a time.
// Parent and rank tables sit in two one-read one-write RAMs with registered
// read data; each parent link is followed once on the walk and once on the
// rewrite. Each request first folds node fields at or above NODES into range
// (no fold steps when NODES >= 1024); a find then walks node_a to its root
// and rewrites the path to point at that root. A merge does both walks and
// rewrites, plus two rank reads when the roots differ.
// After reset the block clears both tables, entry by entry, with in_ready_o
// low; then every node is its own root with rank zero.
// A finished result sits in an output register, so the next item is taken
// while the receiver stalls; a second result waits until that register
// frees.
module disjoint_set_union_engine_unit #(
  parameter int NODES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dsu_pkg::dsu_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dsu_pkg::dsu_rsp_t out_data_o
);

  import dsu_pkg::*;

  localparam int IW        = $clog2(NODES);
  localparam int RED_STEPS = red_steps(NODES);
  localparam int KW        = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

  dsu_state_e state_q, state_d;

  logic [IW-1:0]    clr_q, clr_d;
  logic             out_valid_q, out_valid_d;
  dsu_rsp_t         out_q, out_d;
  dsu_op_e          op_q, op_d;
  logic [NodeW-1:0] a_q, a_d, b_q, b_d;
  logic [KW-1:0]    k_q, k_d;
  logic             phase_q, phase_d;
  logic [IW-1:0]    cur_q, cur_d, root_q, root_d, ra_q, ra_d;
  logic [RankW-1:0] rra_q, rra_d;
  logic [IW-1:0]    res_root_q, res_root_d;
  logic             res_joined_q, res_joined_d;

  logic             p_we;
  logic [IW-1:0]    p_waddr, p_wdata, p_raddr, p_rdata;
  logic             r_we;
  logic [IW-1:0]    r_waddr, r_raddr;
  logic [RankW-1:0] r_wdata, r_rdata;

  logic             walk_found, comp_done, out_free, a_wins;
  logic [NodeW:0]   div;
  logic [NodeW-1:0] a_red, b_red;
  logic [IW-1:0]    start;

  dsu_ram #(.Width(IW), .Depth(NODES)) u_parent (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(p_waddr),
    .wdata_i(p_wdata),
    .raddr_i(p_raddr),
    .rdata_o(p_rdata)
  );

  dsu_ram #(.Width(RankW), .Depth(NODES)) u_rank (
    .clk_i  (clk_i),
    .we_i   (r_we),
    .waddr_i(r_waddr),
    .wdata_i(r_wdata),
    .raddr_i(r_raddr),
    .rdata_o(r_rdata)
  );

  assign walk_found = (p_rdata == cur_q);
  assign comp_done  = (cur_q == root_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign a_wins     = (rra_q > r_rdata);
  assign start      = phase_q ? IW'(b_q) : IW'(a_q);

  assign div   = (NodeW + 1)'(NODES) << k_q;
  assign a_red = ({1'b0, a_q} >= div) ? a_q - div[NodeW-1:0] : a_q;
  assign b_red = ({1'b0, b_q} >= div) ? b_q - div[NodeW-1:0] : b_q;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      SClear: begin
        if (clr_q == IW'(NODES - 1)) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (in_valid_i) begin
          state_d = (RED_STEPS > 0) ? SReduce : SWalk;
        end
      end
      SReduce: begin
        if (k_q == '0) begin
          state_d = SWalk;
        end
      end
      SWalk: begin
        if (walk_found) begin
          state_d = SComp;
        end
      end
      SComp: begin
        if (comp_done) begin
          if (op_q == OpFind) begin
            state_d = SOut;
          end else if (!phase_q) begin
            state_d = SWalk;
          end else if (root_q == ra_q) begin
            state_d = SOut;
          end else begin
            state_d = SRankA;
          end
        end
      end
      SRankA: state_d = SRankB;
      SRankB: state_d = SOut;
      SOut: begin
        if (out_free) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    clr_d        = clr_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    op_d         = op_q;
    a_d          = a_q;
    b_d          = b_q;
    k_d          = k_q;
    phase_d      = phase_q;
    cur_d        = cur_q;
    root_d       = root_q;
    ra_d         = ra_q;
    rra_d        = rra_q;
    res_root_d   = res_root_q;
    res_joined_d = res_joined_q;
    p_we         = 1'b0;
    p_waddr      = cur_q;
    p_wdata      = root_q;
    p_raddr      = cur_q;
    r_we         = 1'b0;
    r_waddr      = root_q;
    r_wdata      = r_rdata + RankW'(1);
    r_raddr      = ra_q;
    case (state_q)
      SClear: begin
        p_we    = 1'b1;
        p_waddr = clr_q;
        p_wdata = clr_q;
        r_we    = 1'b1;
        r_waddr = clr_q;
        r_wdata = '0;
        clr_d   = clr_q + IW'(1);
      end
      SIdle: begin
        op_d    = in_data_i.opcode;
        a_d     = in_data_i.node_a;
        b_d     = in_data_i.node_b;
        phase_d = 1'b0;
        k_d     = KW'(RED_STEPS - 1);
        cur_d   = IW'(in_data_i.node_a);
        p_raddr = IW'(in_data_i.node_a);
      end
      SReduce: begin
        a_d     = a_red;
        b_d     = b_red;
        k_d     = k_q - KW'(1);
        cur_d   = IW'(a_red);
        p_raddr = IW'(a_red);
      end
      SWalk: begin
        if (walk_found) begin
          root_d  = cur_q;
          cur_d   = start;
          p_raddr = start;
        end else begin
          cur_d   = p_rdata;
          p_raddr = p_rdata;
        end
      end
      SComp: begin
        if (comp_done) begin
          if (op_q == OpFind) begin
            res_root_d   = root_q;
            res_joined_d = 1'b0;
          end else if (!phase_q) begin
            ra_d    = root_q;
            phase_d = 1'b1;
            cur_d   = IW'(b_q);
            p_raddr = IW'(b_q);
          end else begin
            res_root_d   = ra_q;
            res_joined_d = 1'b1;
            r_raddr      = ra_q;
          end
        end else begin
          p_we    = 1'b1;
          p_waddr = cur_q;
          p_wdata = root_q;
          cur_d   = p_rdata;
          p_raddr = p_rdata;
        end
      end
      SRankA: begin
        rra_d   = r_rdata;
        r_raddr = root_q;
      end
      SRankB: begin
        res_joined_d = 1'b0;
        p_we         = 1'b1;
        if (a_wins) begin
          p_waddr    = root_q;
          p_wdata    = ra_q;
          res_root_d = ra_q;
        end else begin
          p_waddr    = ra_q;
          p_wdata    = root_q;
          res_root_d = root_q;
          r_we       = (rra_q == r_rdata) && (r_rdata != RankMax);
          r_waddr    = root_q;
        end
      end
      SOut: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.root           = NodeW'(res_root_q);
          out_d.already_joined = res_joined_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q        <= out_d;
    op_q         <= op_d;
    a_q          <= a_d;
    b_q          <= b_d;
    cur_q        <= cur_d;
    root_q       <= root_d;
    ra_q         <= ra_d;
    rra_q        <= rra_d;
    res_root_q   <= res_root_d;
    res_joined_q <= res_joined_d;
  end

`ifndef ASSERT_OFF
  a_no_self_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_we && (state_q != SClear) |-> p_wdata != p_waddr)
    else $error("parent write would make a node its own parent outside clearing");

  a_joined_only_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SOut) && res_joined_q |-> op_q == OpMerge)
    else $error("already_joined raised for a find");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SWalk) || (state_q == SComp) |-> cur_q <= IW'(NODES - 1))
    else $error("walk left the node range");
`endif

endmodule

// ----- sim/dsu_union_checker.sv -----
`timescale 1ns / 1ps
module dsu_union_checker
  import dsu_pkg::*;
#(
  parameter int NODES = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_o,
  input  dsu_req_t in_data_i,
  input  logic     out_valid_o,
  input  logic     out_ready_i,
  input  dsu_rsp_t out_data_o,
  output int       errors_o,
  output int       outstanding_o
);

  logic [NodeW-1:0] link_q   [NODES];
  logic [RankW-1:0] height_q [NODES];
  dsu_rsp_t         roots_due [$];
  dsu_rsp_t         due;
  int               bad;
  int               seen;
  int               delta;

  function automatic logic [NodeW-1:0] seek_root(logic [NodeW-1:0] n);
    logic [NodeW-1:0] r;
    logic [NodeW-1:0] cur;
    logic [NodeW-1:0] nxt;
    r = n;
    while (link_q[r] != r) r = link_q[r];
    cur = n;
    while (cur != r) begin
      nxt = link_q[cur];
      link_q[cur] = r;
      cur = nxt;
    end
    return r;
  endfunction

  function automatic dsu_rsp_t predict_union(dsu_req_t q);
    dsu_rsp_t         p;
    logic [NodeW-1:0] ra;
    logic [NodeW-1:0] rb;
    p = '0;
    if (q.opcode == OpFind) begin
      p.root = seek_root(q.node_a);
    end else begin
      ra = seek_root(q.node_a);
      rb = seek_root(q.node_b);
      if (ra == rb) begin
        p.root = ra;
        p.already_joined = 1'b1;
      end else if (height_q[ra] > height_q[rb]) begin
        link_q[rb] = ra;
        p.root = ra;
      end else begin
        link_q[ra] = rb;
        // saturate the rank at its width
        if (height_q[ra] == height_q[rb] && height_q[rb] != RankMax) begin
          height_q[rb] = height_q[rb] + 1'b1;
        end
        p.root = rb;
      end
    end
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) begin
        link_q[i]   = NodeW'(i);
        height_q[i] = '0;
      end
      roots_due.delete();
      bad = 0;
      seen = 0;
      errors_o <= 0;
      outstanding_o <= 0;
    end else begin
      delta = 0;
      if (out_valid_o && out_ready_i) begin
        seen++;
        delta--;
        if (roots_due.size() == 0) begin
          bad++;
          if (bad <= 10) begin
            $display("checker: item %0d out with none due, root %0d joined %0b",
                     seen, out_data_o.root, out_data_o.already_joined);
          end
        end else begin
          due = roots_due.pop_front();
          if (due.root !== out_data_o.root ||
              due.already_joined !== out_data_o.already_joined) begin
            bad++;
            if (bad <= 10) begin
              $display("checker: item %0d root exp %0d got %0d, joined exp %0b got %0b",
                       seen, due.root, out_data_o.root,
                       due.already_joined, out_data_o.already_joined);
            end
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        roots_due = {roots_due, predict_union(in_data_i)};
        delta++;
      end
      errors_o <= bad;
      outstanding_o <= outstanding_o + delta;
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import dsu_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int ItemTotal  = 1050;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  dsu_req_t in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  dsu_rsp_t out_data_o;

  int errors;
  int outstanding;
  int cycles = 0;
  int snd_idle = 25;
  int rcv_idle = 49;
  int n_find = 0;
  int n_merge = 0;
  int n_drain = 0;

  disjoint_set_union_engine_unit #(
    .NODES(1024)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  dsu_union_checker #(
    .NODES(1024)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o),
    .errors_o     (errors),
    .outstanding_o(outstanding)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rcv_idle);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic send_req(input dsu_op_e op, input logic [NodeW-1:0] a,
                          input logic [NodeW-1:0] b);
    dsu_req_t r;
    r.opcode = op;
    r.node_a = a;
    r.node_b = b;
    if ($urandom_range(0, 99) < snd_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < snd_idle);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OpFind) n_find++;
    else n_merge++;
  endtask

  // binomial build over 2**lg nodes from base: roots stay on the block ends
  task automatic grow_tree(input logic [NodeW-1:0] base, input int lg);
    int s;
    for (int l = 0; l < lg; l++) begin
      s = 1 << l;
      for (int j = 0; j < (1 << lg) / (2 * s); j++) begin
        send_req(OpMerge, NodeW'(base + j * 2 * s + s - 1),
                 NodeW'(base + j * 2 * s + 2 * s - 1));
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    n_drain++;
  endtask

  function automatic logic [NodeW-1:0] pick_node(logic [NodeW-1:0] pool);
    if ($urandom_range(0, 99) < 40) return NodeW'($urandom);
    return NodeW'(pool + $urandom_range(0, 63));
  endfunction

  initial begin
    logic [NodeW-1:0] pool;
    int               sent;
    int               pick;
    int               drained_mid;
    pool = '0;
    drained_mid = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    grow_tree('0, 4);
    send_req(OpFind, 10'd0, 10'd1023);
    send_req(OpFind, 10'd15, 10'd0);
    send_req(OpMerge, 10'd0, 10'd15);
    send_req(OpMerge, 10'd1023, 10'd1023);
    send_req(OpFind, 10'd1023, 10'd1023);
    send_req(OpMerge, 10'd1023, 10'd1022);
    send_req(OpMerge, 10'd1022, 10'd0);
    send_req(OpFind, 10'd1023, 10'd512);

    sent = n_find + n_merge;
    while (sent < ItemTotal) begin
      if (sent < 370) begin
        snd_idle = 25;
        rcv_idle = 49;
      end else if (sent < 720) begin
        snd_idle = 49;
        rcv_idle = 25;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      if (!drained_mid && sent >= 500) begin
        drain();
        drained_mid = 1;
      end
      if ($urandom_range(0, 149) == 0) pool = NodeW'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        grow_tree(NodeW'($urandom), $urandom_range(2, 4));
      end else if (pick < 54) begin
        send_req(OpFind, pick_node(pool), NodeW'($urandom));
      end else begin
        send_req(OpMerge, pick_node(pool), pick_node(pool));
      end
      sent = n_find + n_merge;
    end

    drain();
    repeat (64) @(posedge clk_i);
    $display("summary: %0d finds and %0d merges over three idle profiles,", n_find, n_merge);
    $display("summary: binomial tree builds, wide and pooled nodes, %0d full drains", n_drain);
    if (errors == 0 && outstanding == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/dsu_pkg.sv
src/dsu_ram.sv
src/disjoint_set_union_engine_unit.sv
sim/dsu_union_checker.sv
sim/tb_top.sv
